>>> sv/selective_repeat_receiver_defines.svh
// Assertion macros shared by the selective-repeat receiver checkers.
// No dependencies; included by the checker file.
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/srr_pkg.sv
// Shared types and constants of the selective-repeat receiver.
// No dependencies; used by every other file of the block but the assertion macro header.
package srr_pkg;

  localparam int SEQ_W     = 4;
  localparam int FIELD_W   = 32;
  localparam int PL_WORD_W = 64;
  localparam int PL_TOP_W  = 32;
  localparam int PAYLOAD_W = 2 * PL_WORD_W + PL_TOP_W;
  localparam int CHK_W     = 10;

  localparam logic [CHK_W-1:0] ACK_BASE = 10'd960;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef struct packed {
    logic load_in;
    logic sum_en;
    logic check_en;
    logic write_en;
    logic load_data;
    logic load_ack;
  } srr_cmd_t;

  typedef struct packed {
    logic good;
    logic slot_hit;
  } srr_status_t;

endpackage

>>> sv/srr_if.sv
// Handshake channels of the selective-repeat receiver: packet in, result out.
// Depends on srr_pkg.
interface srr_in_if;
  import srr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [SEQ_W-1:0]           seq_number;
  logic signed [FIELD_W-1:0]  ack_field;
  logic signed [FIELD_W-1:0]  check_field;
  logic [PL_WORD_W-1:0]       payload_low;
  logic [PL_WORD_W-1:0]       payload_mid;
  logic [PL_TOP_W-1:0]        payload_top;

  modport source (output valid, seq_number, ack_field, check_field, payload_low,
                  payload_mid, payload_top, input ready);
  modport sink (input valid, seq_number, ack_field, check_field, payload_low,
                payload_mid, payload_top, output ready);
endinterface

interface srr_out_if;
  import srr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  result_kind;
  logic [SEQ_W-1:0]      ack_number;
  logic [CHK_W-1:0]      ack_checksum;
  logic [PL_WORD_W-1:0]  out_payload_low;
  logic [PL_WORD_W-1:0]  out_payload_mid;
  logic [PL_TOP_W-1:0]   out_payload_top;
  logic                  last_result;

  modport source (output valid, result_kind, ack_number, ack_checksum,
                  out_payload_low, out_payload_mid, out_payload_top, last_result,
                  input ready);
  modport sink (input valid, result_kind, ack_number, ack_checksum,
                out_payload_low, out_payload_mid, out_payload_top, last_result,
                output ready);
endinterface

>>> sv/srr_controller.sv
// Sequencing state machine of the selective-repeat receiver.
// Depends on srr_pkg; drives srr_datapath through srr_cmd_t.
module srr_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  srr_pkg::srr_status_t status,
  output srr_pkg::srr_cmd_t    cmd
);
  import srr_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SUM       = 3'd1;
  localparam logic [2:0] ST_CHECK     = 3'd2;
  localparam logic [2:0] ST_WRITE     = 3'd3;
  localparam logic [2:0] ST_LOOK      = 3'd4;
  localparam logic [2:0] ST_LOAD      = 3'd5;
  localparam logic [2:0] ST_WAIT_DATA = 3'd6;
  localparam logic [2:0] ST_WAIT_ACK  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check_en = 1'b1;
        state_next   = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write_en = 1'b1;
        if (status.good) begin
          state_next = ST_LOOK;
        end else begin
          cmd.load_ack = 1'b1;
          state_next   = ST_WAIT_ACK;
        end
      end
      // memory read of the expected slot is in flight during this state
      ST_LOOK: begin
        if (status.slot_hit) begin
          state_next = ST_LOAD;
        end else begin
          cmd.load_ack = 1'b1;
          state_next   = ST_WAIT_ACK;
        end
      end
      ST_LOAD: begin
        cmd.load_data = 1'b1;
        state_next    = ST_WAIT_DATA;
      end
      ST_WAIT_DATA: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_LOOK;
        end
      end
      ST_WAIT_ACK: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/srr_datapath.sv
// Datapath of the selective-repeat receiver: checksum, window test, slot
// buffer memory, expected counter and result register. Depends on srr_pkg.
module srr_datapath #(
  parameter int SEQ_SPACE = 12,
  parameter int WINDOW    = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  srr_pkg::srr_cmd_t                  cmd,
  output srr_pkg::srr_status_t               status,
  input  logic [srr_pkg::SEQ_W-1:0]          seq_number,
  input  logic signed [srr_pkg::FIELD_W-1:0] ack_field,
  input  logic signed [srr_pkg::FIELD_W-1:0] check_field,
  input  logic [srr_pkg::PL_WORD_W-1:0]      payload_low,
  input  logic [srr_pkg::PL_WORD_W-1:0]      payload_mid,
  input  logic [srr_pkg::PL_TOP_W-1:0]       payload_top,
  output logic                               result_kind,
  output logic [srr_pkg::SEQ_W-1:0]          ack_number,
  output logic [srr_pkg::CHK_W-1:0]          ack_checksum,
  output logic [srr_pkg::PL_WORD_W-1:0]      out_payload_low,
  output logic [srr_pkg::PL_WORD_W-1:0]      out_payload_mid,
  output logic [srr_pkg::PL_TOP_W-1:0]       out_payload_top,
  output logic                               last_result
);
  import srr_pkg::*;

  localparam int IDX_W = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int EXT_W = SEQ_W + 1;
  localparam logic [EXT_W-1:0] SPACE_X  = EXT_W'(SEQ_SPACE);
  localparam logic [EXT_W-1:0] WIN_X    = EXT_W'(WINDOW);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEQ_SPACE - 1);

  // sum of eight bytes, each sign-extended
  function automatic logic signed [10:0] byte_sum8(input logic [PL_WORD_W-1:0] w);
    logic signed [10:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 11'(signed'(w[8*i +: 8]));
    end
    return s;
  endfunction

  logic [SEQ_W-1:0]          seq_r;
  logic signed [FIELD_W-1:0] ack_r;
  logic [FIELD_W-1:0]        chk_r;
  logic [PAYLOAD_W-1:0]      pl_r;
  logic [FIELD_W-1:0]        base;
  logic signed [10:0]        psum_low;
  logic signed [10:0]        psum_mid;
  logic signed [10:0]        psum_top;
  logic                      good;
  logic [SEQ_W-1:0]          ack_num;
  logic [IDX_W-1:0]          expected;
  logic [SEQ_SPACE-1:0]      slot_valid;
  logic [PAYLOAD_W-1:0]      mem [SEQ_SPACE];
  logic [PAYLOAD_W-1:0]      rd_data;

  logic signed [12:0]        bsum;
  logic [FIELD_W-1:0]        total;
  logic [EXT_W-1:0]          seq_x;
  logic [EXT_W-1:0]          exp_x;
  logic [EXT_W-1:0]          seq_gap;
  logic                      in_win;
  logic                      pass;
  logic [IDX_W-1:0]          prev_exp;
  logic [IDX_W-1:0]          wr_idx;
  logic                      wr_en;

  always_comb begin
    bsum     = 13'(psum_low) + 13'(psum_mid) + 13'(psum_top);
    total    = base + FIELD_W'(bsum);
    seq_x    = {1'b0, seq_r};
    exp_x    = EXT_W'(expected);
    seq_gap  = (seq_x >= exp_x) ? (seq_x - exp_x) : (seq_x + SPACE_X - exp_x);
    in_win   = (seq_x < SPACE_X) && (seq_gap < WIN_X);
    pass     = (total == chk_r) && in_win;
    prev_exp = (expected == '0) ? LAST_IDX : (expected - 1'b1);
    wr_idx   = seq_r[IDX_W-1:0];
    // a duplicate keeps the payload first buffered
    wr_en    = cmd.write_en && good && !slot_valid[wr_idx];
  end

  assign status.good     = good;
  assign status.slot_hit = slot_valid[expected];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      seq_r <= seq_number;
      ack_r <= ack_field;
      chk_r <= check_field;
      pl_r  <= {payload_top, payload_mid, payload_low};
    end
    if (cmd.sum_en) begin
      base     <= FIELD_W'(ack_r) + FIELD_W'(seq_r);
      psum_low <= byte_sum8(pl_r[PL_WORD_W-1:0]);
      psum_mid <= byte_sum8(pl_r[2*PL_WORD_W-1:PL_WORD_W]);
      psum_top <= byte_sum8({{(PL_WORD_W-PL_TOP_W){1'b0}}, pl_r[PAYLOAD_W-1:2*PL_WORD_W]});
    end
    if (cmd.check_en) begin
      ack_num <= pass ? seq_r : SEQ_W'(prev_exp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      good <= 1'b0;
    end else if (cmd.check_en) begin
      good <= pass;
    end
  end

  // slot buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= pl_r;
    end
    rd_data <= mem[expected];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      expected   <= '0;
    end else begin
      if (wr_en) begin
        slot_valid[wr_idx] <= 1'b1;
      end
      if (cmd.load_data) begin
        slot_valid[expected] <= 1'b0;
        expected             <= (expected == LAST_IDX) ? '0 : (expected + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_data) begin
      result_kind     <= KIND_DATA;
      ack_number      <= '0;
      ack_checksum    <= '0;
      out_payload_low <= rd_data[PL_WORD_W-1:0];
      out_payload_mid <= rd_data[2*PL_WORD_W-1:PL_WORD_W];
      out_payload_top <= rd_data[PAYLOAD_W-1:2*PL_WORD_W];
      last_result     <= 1'b0;
    end else if (cmd.load_ack) begin
      result_kind     <= KIND_ACK;
      ack_number      <= ack_num;
      ack_checksum    <= ACK_BASE + CHK_W'(ack_num);
      out_payload_low <= '0;
      out_payload_mid <= '0;
      out_payload_top <= '0;
      last_result     <= 1'b1;
    end
  end

endmodule

>>> sv/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver. One packet is taken at a time: after it is
// accepted the checksum and window test run in the sum, check and write
// states. A rejected packet then gives its ack item. An accepted packet goes
// on to the slot lookup, each buffered in-order payload comes out as a data
// item (slot memory read, result load, hand-off), and the packet closes with
// one ack item; 0 to WINDOW payloads are delivered per packet. Input ready
// stays low until the ack item is taken.
// Depends on srr_pkg, srr_if, srr_controller and srr_datapath.
module selective_repeat_receiver #(
  parameter int SEQ_SPACE = 12,
  parameter int WINDOW    = 6
) (
  input logic       clk,
  input logic       rst,
  srr_in_if.sink    packet,
  srr_out_if.source result
);
  import srr_pkg::*;

  srr_cmd_t    cmd;
  srr_status_t status;

  srr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (packet.valid),
    .in_ready  (packet.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  srr_datapath #(
    .SEQ_SPACE (SEQ_SPACE),
    .WINDOW    (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .seq_number      (packet.seq_number),
    .ack_field       (packet.ack_field),
    .check_field     (packet.check_field),
    .payload_low     (packet.payload_low),
    .payload_mid     (packet.payload_mid),
    .payload_top     (packet.payload_top),
    .result_kind     (result.result_kind),
    .ack_number      (result.ack_number),
    .ack_checksum    (result.ack_checksum),
    .out_payload_low (result.out_payload_low),
    .out_payload_mid (result.out_payload_mid),
    .out_payload_top (result.out_payload_top),
    .last_result     (result.last_result)
  );

endmodule

>>> sv/srr_checker.sv
// Port-level assertions for the selective-repeat receiver, bound to the top.
// Depends on srr_pkg and selective_repeat_receiver_defines.svh.
`include "selective_repeat_receiver_defines.svh"

module srr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       result_kind,
  input logic [srr_pkg::SEQ_W-1:0]  ack_number,
  input logic [srr_pkg::CHK_W-1:0]  ack_checksum,
  input logic                       last_result
);
  import srr_pkg::*;

  `SRR_ASSERT_IMP(ack_csum_a, clk, rst, out_valid && (result_kind == KIND_ACK), ack_checksum == ACK_BASE + CHK_W'(ack_number), "ack checksum mismatch")
  `SRR_ASSERT_IMP(last_kind_a, clk, rst, out_valid, last_result == result_kind, "last flag not on ack item only")
  `SRR_ASSERT_IMP(busy_a, clk, rst, out_valid, !in_ready, "packet taken while results pending")
  `SRR_ASSERT_NXT(accept_a, clk, rst, in_valid && in_ready, !in_ready && !out_valid, "no busy phase after packet accept")
  `SRR_ASSERT_NXT(hold_a, clk, rst, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(ack_number), "stalled result changed")

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (packet.valid),
  .in_ready     (packet.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .result_kind  (result.result_kind),
  .ack_number   (result.ack_number),
  .ack_checksum (result.ack_checksum),
  .last_result  (result.last_result)
);

>>> dv/tb.sv
// Self-checking testbench for the selective-repeat ARQ receiver.
// Depends on srr_pkg, srr_if and selective_repeat_receiver; predicts the
// delivered payloads and acks of every packet and checks them in order.
`timescale 1ns / 1ps

module tb;
  import srr_pkg::*;

  localparam int SEQ_SPACE = 12;
  localparam int WINDOW    = 6;
  localparam int NUM_BYTES = 20;

  typedef struct {
    logic [SEQ_W-1:0]          seq;
    logic signed [FIELD_W-1:0] ack;
    logic signed [FIELD_W-1:0] chk;
    logic [PL_WORD_W-1:0]      lo;
    logic [PL_WORD_W-1:0]      mid;
    logic [PL_TOP_W-1:0]       top;
  } packet_t;

  typedef struct {
    logic                 kind;
    logic [SEQ_W-1:0]     ackn;
    logic [CHK_W-1:0]     acks;
    logic [PL_WORD_W-1:0] lo;
    logic [PL_WORD_W-1:0] mid;
    logic [PL_TOP_W-1:0]  top;
    logic                 last;
  } result_t;

  logic clk;
  logic rst;

  srr_in_if  pkt_ch ();
  srr_out_if res_ch ();

  selective_repeat_receiver #(
    .SEQ_SPACE(SEQ_SPACE),
    .WINDOW   (WINDOW)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .packet(pkt_ch),
    .result(res_ch)
  );

  // Receiver state as the testbench sees it
  int                     next_seq;
  bit                     held [SEQ_SPACE];
  logic [PAYLOAD_W-1:0]   held_pl [SEQ_SPACE];
  result_t                due_results [$];

  int mismatches;
  bit quiet;        // no idling on either side
  int hold_cycles;  // long receiver hold-off, counted down by the ready driver

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [31:0] packet_sum(input packet_t p);
    logic [31:0]          s;
    logic [PAYLOAD_W-1:0] all_bytes;
    all_bytes = {p.top, p.mid, p.lo};
    s = 32'(p.seq) + 32'(p.ack);
    for (int i = 0; i < NUM_BYTES; i++)
      s += {{24{all_bytes[8*i+7]}}, all_bytes[8*i +: 8]};
    return s;
  endfunction

  // Fill in the checksum; a bad one is off by a nonzero amount
  function automatic packet_t sealed(input packet_t p, input bit good);
    logic [31:0] off;
    p.chk = packet_sum(p);
    if (!good) begin
      off = $urandom;
      if (off == 0) off = 1;
      p.chk = p.chk + off;
    end
    return p;
  endfunction

  function automatic packet_t random_packet(input int seq, input bit good);
    packet_t p;
    p.seq = SEQ_W'(seq);
    p.ack = $urandom;
    p.chk = '0;
    p.lo  = {$urandom, $urandom};
    p.mid = {$urandom, $urandom};
    p.top = $urandom;
    return sealed(p, good);
  endfunction

  function automatic int seq_at(input int ahead);
    return (next_seq + ahead) % SEQ_SPACE;
  endfunction

  function automatic int sender_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Predict the results of one accepted packet
  task automatic arq_receive(input packet_t p);
    result_t     r;
    int          ahead;
    bit          fits;
    logic [3:0]  ackn;
    fits = 1'b0;
    if (p.seq < SEQ_SPACE) begin
      ahead = (int'(p.seq) + SEQ_SPACE - next_seq) % SEQ_SPACE;
      fits = ahead < WINDOW;
    end
    if (packet_sum(p) == p.chk && fits) begin
      // a duplicate keeps the first payload
      if (!held[p.seq]) begin
        held_pl[p.seq] = {p.top, p.mid, p.lo};
        held[p.seq] = 1'b1;
      end
      while (held[next_seq]) begin
        r.kind = KIND_DATA;
        r.ackn = '0;
        r.acks = '0;
        {r.top, r.mid, r.lo} = held_pl[next_seq];
        r.last = 1'b0;
        due_results.push_back(r);
        held[next_seq] = 1'b0;
        next_seq = (next_seq + 1) % SEQ_SPACE;
      end
      ackn = p.seq;
    end else begin
      ackn = SEQ_W'((next_seq + SEQ_SPACE - 1) % SEQ_SPACE);
    end
    r.kind = KIND_ACK;
    r.ackn = ackn;
    r.acks = ACK_BASE + CHK_W'(ackn);
    r.lo   = '0;
    r.mid  = '0;
    r.top  = '0;
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  // Offer one packet after a gap; returns at the edge that takes it
  task automatic send_packet(input packet_t p, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      pkt_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pkt_ch.seq_number  = p.seq;
    pkt_ch.ack_field   = p.ack;
    pkt_ch.check_field = p.chk;
    pkt_ch.payload_low = p.lo;
    pkt_ch.payload_mid = p.mid;
    pkt_ch.payload_top = p.top;
    pkt_ch.valid       = 1'b1;
    @(posedge clk);
    while (!pkt_ch.ready) @(posedge clk);
    arq_receive(p);
  endtask

  task automatic send_good(input int seq);
    send_packet(random_packet(seq, 1'b1), sender_gap());
  endtask

  // Result side: random stalls plus the long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        res_ch.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        res_ch.ready = 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) - 1
                                                 : $urandom_range(1, 3) - 1;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = due_results.pop_front();
          compare_field("result_kind", 64'(res_ch.result_kind), 64'(want.kind));
          compare_field("ack_number", 64'(res_ch.ack_number), 64'(want.ackn));
          compare_field("ack_checksum", 64'(res_ch.ack_checksum), 64'(want.acks));
          compare_field("out_payload_low", res_ch.out_payload_low, want.lo);
          compare_field("out_payload_mid", res_ch.out_payload_mid, want.mid);
          compare_field("out_payload_top", 64'(res_ch.out_payload_top), 64'(want.top));
          compare_field("last_result", 64'(res_ch.last_result), 64'(want.last));
        end
      end
    end
  end

  // Checksum wrap both ways, all-zero and all-one payloads, bad extreme checksums
  task automatic test_field_extremes();
    packet_t p;
    p = '{seq: SEQ_W'(seq_at(0)), ack: 32'sh0, chk: 32'sh0, lo: '0, mid: '0, top: '0};
    send_packet(sealed(p, 1'b1), sender_gap());
    p = '{seq: SEQ_W'(seq_at(0)), ack: 32'sh7FFF_FFFF, chk: 32'sh0,
          lo: {8{8'h7F}}, mid: {8{8'h7F}}, top: {4{8'h7F}}};
    send_packet(sealed(p, 1'b1), sender_gap());
    p = '{seq: SEQ_W'(seq_at(0)), ack: 32'sh8000_0000, chk: 32'sh0,
          lo: {8{8'h80}}, mid: {8{8'h80}}, top: {4{8'h80}}};
    send_packet(sealed(p, 1'b1), sender_gap());
    p = '{seq: SEQ_W'(seq_at(0)), ack: -32'sd1, chk: 32'sh0,
          lo: '1, mid: '1, top: '1};
    send_packet(sealed(p, 1'b1), sender_gap());
    p = '{seq: SEQ_W'(seq_at(0)), ack: 32'sh0, chk: 32'sh8000_0000,
          lo: '1, mid: '0, top: '1};
    send_packet(p, sender_gap());
    p.chk = 32'sh7FFF_FFFF;
    send_packet(p, sender_gap());
  endtask

  // Out-of-order arrival, duplicate in the window keeps the first payload
  task automatic test_reordering();
    int base;
    base = next_seq;
    send_good((base + 2) % SEQ_SPACE);
    send_good((base + 1) % SEQ_SPACE);
    send_good((base + 2) % SEQ_SPACE);
    send_good(base);
  endtask

  // Whole window buffered, then the head packet releases all of it
  task automatic test_full_window();
    int base;
    base = next_seq;
    for (int d = WINDOW - 1; d >= 0; d--)
      send_good((base + d) % SEQ_SPACE);
  endtask

  task automatic test_rejects();
    send_packet(random_packet(seq_at(0), 1'b0), sender_gap());
    send_good(seq_at(WINDOW));
    send_good(seq_at(SEQ_SPACE - 1));
    for (int s = SEQ_SPACE; s < 16; s++)
      send_good(s);
  endtask

  task automatic test_random_traffic(input int count);
    int sent;
    int r;
    int k;
    int base;
    int tmp;
    int j;
    int order [WINDOW];
    packet_t p;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // shuffled run of in-window packets starting at the expected one
        k = $urandom_range(1, WINDOW);
        base = next_seq;
        for (int i = 0; i < k; i++) order[i] = i;
        for (int i = k - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < k; i++) send_good((base + order[i]) % SEQ_SPACE);
        sent += k;
      end else begin
        if (r < 60)
          p = random_packet(seq_at($urandom_range(0, WINDOW - 1)), 1'b1);
        else if (r < 70)
          p = random_packet(seq_at($urandom_range(WINDOW, SEQ_SPACE - 1)), 1'b1);
        else if (r < 75)
          p = random_packet($urandom_range(SEQ_SPACE, 15), 1'b1);
        else if (r < 90)
          p = random_packet($urandom_range(0, 15), 1'b0);
        else begin
          p = random_packet($urandom_range(0, 15), 1'b1);
          p.chk = $urandom;
        end
        send_packet(p, sender_gap());
        sent++;
      end
    end
  endtask

  // Result side held off while packets keep coming
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 12; i++)
      send_packet(random_packet(seq_at($urandom_range(0, WINDOW - 1)), 1'b1), 0);
  endtask

  initial begin
    rst = 1'b1;
    mismatches = 0;
    quiet = 1'b0;
    hold_cycles = 0;
    next_seq = 0;
    foreach (held[i]) held[i] = 1'b0;
    pkt_ch.valid       = 1'b0;
    pkt_ch.seq_number  = '0;
    pkt_ch.ack_field   = '0;
    pkt_ch.check_field = '0;
    pkt_ch.payload_low = '0;
    pkt_ch.payload_mid = '0;
    pkt_ch.payload_top = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_reordering();
    test_full_window();
    test_rejects();
    test_random_traffic(200);
    test_backpressure();
    quiet = 1'b1;
    test_random_traffic(100);
    quiet = 1'b0;
    test_random_traffic(140);

    @(negedge clk);
    pkt_ch.valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/srr_pkg.sv
sv/srr_if.sv
sv/srr_controller.sv
sv/srr_datapath.sv
sv/selective_repeat_receiver.sv
sv/srr_checker.sv
dv/tb.sv
